### hdl/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg
// types and constants shared by the slice kind scanner modules
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned StageW = 3;
  localparam int unsigned KindW  = 2;

  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [StageW-1:0] stage_t;

  typedef enum logic [KindW-1:0] {
    KIND_P = 2'd0,
    KIND_B = 2'd1,
    KIND_I = 2'd2
  } kind_t;

  // start-code stages
  localparam stage_t STG_IDLE   = 3'd0;
  localparam stage_t STG_ZERO2  = 3'd2;
  localparam stage_t STG_ZERO3  = 3'd3;
  localparam stage_t STG_PREFIX = 3'd4;
  localparam stage_t STG_SLICE  = 3'd5;

  // classification masks
  localparam byte_t MASK_7C = 8'h7c;
  localparam byte_t MASK_40 = 8'h40;
  localparam byte_t MASK_70 = 8'h70;
  localparam byte_t MASK_7F = 8'h7f;
  localparam byte_t MASK_0F = 8'h0f;
  localparam byte_t P_VAL_A = 8'h18;
  localparam byte_t P_VAL_B = 8'h40;
  localparam byte_t B_VAL_A = 8'h1c;
  localparam byte_t B_VAL_B = 8'h20;
  localparam byte_t I_VAL_A = 8'h08;
  localparam byte_t I_VAL_B = 8'h30;
  localparam byte_t NAL_IDR = 8'h05;
  localparam byte_t NAL_NON = 8'h01;
  localparam byte_t BYTE_00 = 8'h00;
  localparam byte_t BYTE_01 = 8'h01;

  typedef struct packed {
    stage_t stage;
    logic   saw_intra;
    logic   saw_pred;
  } scan_state_t;

  typedef struct packed {
    byte_t stream_byte;
    logic  end_of_stream;
  } scan_item_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  by_end;
  } scan_result_t;

endpackage

`default_nettype wire

### hdl/h264_slice_kind_scanner_top.sv
// ----------------------------------------------------------------------------
// h264_slice_kind_scanner_top
// scans an H.264 byte stream and decides whether its slices are P, B or I
// ----------------------------------------------------------------------------
// a decision passes through the input and result registers before it shows on the out_ ports
// throughput: one byte per cycle, set by the single scan step between the input
// and result registers; the input stalls only while a result waits on out_stall
// reset: synchronous, clears the start-code stage, slice flags and both valid bits
`default_nettype none

module h264_slice_kind_scanner_top (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_stream_byte,
  input  wire        in_end_of_stream,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] out_slice_kind,
  output logic       out_decided_by_end
);
  import sks_pkg::*;

  logic         s1_valid;
  scan_item_t   s1_item;
  scan_item_t   in_item;
  scan_state_t  state_r;
  scan_state_t  state_nxt;
  scan_result_t step_res;
  logic         out_free;
  logic         advance;
  logic         take;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign take     = in_valid && !in_stall;

  assign in_item.stream_byte   = in_stream_byte;
  assign in_item.end_of_stream = in_end_of_stream;

  sks_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .advance    (advance),
    .item_in    (in_item),
    .item_valid (s1_valid),
    .item_out   (s1_item)
  );

  sks_step u_step (
    .state_cur (state_r),
    .item      (s1_item),
    .state_nxt (state_nxt),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  sks_out_reg u_out_reg (
    .clk                (clk),
    .rst_n              (rst_n),
    .advance            (advance),
    .result             (step_res),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_slice_kind     (out_slice_kind),
    .out_decided_by_end (out_decided_by_end)
  );

endmodule

`default_nettype wire

### hdl/sks_in_reg.sv
// ----------------------------------------------------------------------------
// sks_in_reg
// input register holding one stream byte until the scan step consumes it
// ----------------------------------------------------------------------------
`default_nettype none

module sks_in_reg (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  take,
  input  wire                  advance,
  input  sks_pkg::scan_item_t  item_in,
  output logic                 item_valid,
  output sks_pkg::scan_item_t  item_out
);
  import sks_pkg::*;

  logic       valid_r;
  scan_item_t item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= item_in;
    end
  end

  assign item_valid = valid_r;
  assign item_out   = item_r;

endmodule

`default_nettype wire

### hdl/sks_step.sv
// ----------------------------------------------------------------------------
// sks_step
// start-code tracking and slice classification for one byte
// ----------------------------------------------------------------------------
`default_nettype none

module sks_step (
  input  sks_pkg::scan_state_t  state_cur,
  input  sks_pkg::scan_item_t   item,
  output sks_pkg::scan_state_t  state_nxt,
  output sks_pkg::scan_result_t result
);
  import sks_pkg::*;

  always_comb begin
    stage_t st;
    logic   si;
    logic   sp;
    logic   emit;
    kind_t  kind;
    logic   by_end;
    byte_t  b;

    b      = item.stream_byte;
    st     = state_cur.stage;
    si     = state_cur.saw_intra;
    sp     = state_cur.saw_pred;
    emit   = 1'b0;
    kind   = KIND_P;
    by_end = 1'b0;

    if (st == STG_SLICE) begin
      priority if (((b & MASK_7C) == P_VAL_A) || ((b & MASK_40) == P_VAL_B)) begin
        sp = 1'b1;
      end else if (((b & MASK_7C) == B_VAL_A) || ((b & MASK_70) == B_VAL_B)) begin
        emit = 1'b1;
        kind = KIND_B;
      end else if (((b & MASK_7F) == I_VAL_A) || ((b & MASK_70) == I_VAL_B)) begin
        if (!si) begin
          si = 1'b1;
        end else begin
          emit = 1'b1;
          kind = sp ? KIND_P : KIND_I;
        end
      end else begin
        sp = sp;
      end
      st = STG_IDLE;
    end

    if ((st == STG_PREFIX) &&
        (((b & MASK_0F) == NAL_IDR) || ((b & MASK_0F) == NAL_NON))) begin
      st = STG_SLICE;
    end

    priority if ((b == BYTE_00) && (st < STG_ZERO3)) begin
      st = st + 3'd1;
    end else if ((b != BYTE_00) && (b != BYTE_01) && (st != STG_SLICE)) begin
      st = STG_IDLE;
    end else if ((b == BYTE_01) && ((st == STG_ZERO3) || (st == STG_ZERO2))) begin
      st = STG_PREFIX;
    end else begin
      st = st;
    end

    if (!emit && item.end_of_stream) begin
      emit   = 1'b1;
      kind   = sp ? KIND_P : KIND_I;
      by_end = 1'b1;
    end

    if (emit) begin
      state_nxt.stage     = STG_IDLE;
      state_nxt.saw_intra = 1'b0;
      state_nxt.saw_pred  = 1'b0;
    end else begin
      state_nxt.stage     = st;
      state_nxt.saw_intra = si;
      state_nxt.saw_pred  = sp;
    end

    result.valid  = emit;
    result.kind   = kind;
    result.by_end = by_end;
  end

endmodule

`default_nettype wire

### hdl/sks_out_reg.sv
// ----------------------------------------------------------------------------
// sks_out_reg
// result register holding a decision until the receiver takes it
// ----------------------------------------------------------------------------
`default_nettype none

module sks_out_reg (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    advance,
  input  sks_pkg::scan_result_t  result,
  input  wire                    out_stall,
  output logic                   out_valid,
  output logic [1:0]             out_slice_kind,
  output logic                   out_decided_by_end
);
  import sks_pkg::*;

  logic  valid_r;
  kind_t kind_r;
  logic  by_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= result.valid;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      kind_r   <= result.kind;
      by_end_r <= result.by_end;
    end
  end

  assign out_valid          = valid_r;
  assign out_slice_kind     = kind_r;
  assign out_decided_by_end = by_end_r;

endmodule

`default_nettype wire

### hdl/sks_checker.sv
// ----------------------------------------------------------------------------
// sks_checker
// port-level checks for the slice kind scanner
// ----------------------------------------------------------------------------
`default_nettype none

module sks_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [1:0] out_slice_kind,
  input wire       out_decided_by_end
);
  import sks_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slice_kind)
      && $stable(out_decided_by_end))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_slice_kind == KIND_P) || (out_slice_kind == KIND_B)
      || (out_slice_kind == KIND_I))
    else $error("illegal slice kind");

  a_end_not_b: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decided_by_end |-> out_slice_kind != KIND_B)
    else $error("end of stream decision gave B");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no blocked result");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind h264_slice_kind_scanner_top sks_checker u_sks_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_slice_kind     (out_slice_kind),
  .out_decided_by_end (out_decided_by_end)
);

`default_nettype wire

### verif/h264_slice_kind_scanner_top_tb.sv
// ----------------------------------------------------------------------------
// h264_slice_kind_scanner_top_tb
// Self-checking bench for the slice kind scanner. Byte streams are queued up
// front: a short directed run through start codes and slice decisions, then
// random pictures with noise and broken prefixes. A scoreboard model follows
// every accepted byte and predicts each decision. Both handshakes see random
// idles and stalls, except during one stretch with none.
// ----------------------------------------------------------------------------

module h264_slice_kind_scanner_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import sks_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomBytes = 1450;

  typedef struct {
    kind_t kind;
    logic  by_end;
  } decision_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_stream_byte = 8'h00;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_slice_kind;
  logic       out_decided_by_end;

  scan_item_t byte_feed_q[$];
  decision_t  decision_q[$];

  stage_t scan_stage = STG_IDLE;
  logic   intra_seen = 1'b0;
  logic   pred_seen = 1'b0;

  int total_bytes = -1;
  int sent_cnt = 0;
  int accepted_cnt = 0;
  int decision_cnt = 0;
  int end_decision_cnt = 0;
  int kind_cnt[3] = '{0, 0, 0};
  int error_cnt = 0;
  int cycle_cnt = 0;

  wire steady = (sent_cnt >= 500) && (sent_cnt < 800);

  h264_slice_kind_scanner_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_stream_byte     (in_stream_byte),
    .in_end_of_stream   (in_end_of_stream),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_slice_kind     (out_slice_kind),
    .out_decided_by_end (out_decided_by_end)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scoreboard model of the scanner

  function automatic void push_decision(input kind_t kind, input logic by_end);
    decision_t d;
    d.kind = kind;
    d.by_end = by_end;
    decision_q.push_back(d);
    scan_stage = STG_IDLE;
    intra_seen = 1'b0;
    pred_seen = 1'b0;
  endfunction

  function automatic void scan_byte(input byte_t b, input logic eos);
    stage_t st;
    logic   decided;
    st = scan_stage;
    decided = 1'b0;
    if (st == STG_SLICE) begin
      if (((b & MASK_7C) == P_VAL_A) || ((b & MASK_40) == P_VAL_B)) begin
        pred_seen = 1'b1;
      end else if (((b & MASK_7C) == B_VAL_A) || ((b & MASK_70) == B_VAL_B)) begin
        push_decision(KIND_B, 1'b0);
        decided = 1'b1;
      end else if (((b & MASK_7F) == I_VAL_A) || ((b & MASK_70) == I_VAL_B)) begin
        if (!intra_seen) begin
          intra_seen = 1'b1;
        end else begin
          push_decision(pred_seen ? KIND_P : KIND_I, 1'b0);
          decided = 1'b1;
        end
      end
      st = STG_IDLE;
    end
    if (!decided) begin
      if (st == STG_PREFIX && (((b & MASK_0F) == NAL_IDR) || ((b & MASK_0F) == NAL_NON)))
        st = STG_SLICE;
      if (b == BYTE_00 && st < STG_ZERO3)
        st = st + 3'd1;
      else if (b != BYTE_00 && b != BYTE_01 && st != STG_SLICE)
        st = STG_IDLE;
      else if (b == BYTE_01 && (st == STG_ZERO3 || st == STG_ZERO2))
        st = STG_PREFIX;
      scan_stage = st;
      if (eos)
        push_decision(pred_seen ? KIND_P : KIND_I, 1'b1);
    end
  endfunction

  // stimulus

  function automatic void queue_byte(input byte_t b, input logic eos);
    scan_item_t it;
    it.stream_byte = b;
    it.end_of_stream = eos;
    byte_feed_q.push_back(it);
  endfunction

  function automatic byte_t slice_byte_of(input kind_t kind);
    byte_t r;
    logic  alt;
    r = byte_t'($urandom);
    alt = 1'($urandom_range(0, 1));
    case (kind)
      KIND_P:  return alt ? (r | P_VAL_B) : ((r & ~MASK_7C) | P_VAL_A);
      KIND_B:  return alt ? ((r & 8'h8f) | B_VAL_B) : ((r & 8'h83) | B_VAL_A);
      default: return alt ? ((r & 8'h8f) | I_VAL_B) : ((r & 8'h80) | I_VAL_A);
    endcase
  endfunction

  function automatic void queue_picture();
    byte_t hdr;
    byte_t slice;
    int    pick;
    repeat ($urandom_range(0, 3))
      queue_byte(byte_t'($urandom_range(0, 255)), $urandom_range(0, 99) < 2);
    queue_byte(BYTE_00, 1'b0);
    queue_byte(BYTE_00, 1'b0);
    if ($urandom_range(0, 3) == 0)
      queue_byte(BYTE_00, 1'b0);
    if ($urandom_range(0, 99) < 10) begin
      queue_byte(byte_t'($urandom_range(2, 255)), $urandom_range(0, 99) < 5);
      return;
    end
    queue_byte(BYTE_01, 1'b0);
    if ($urandom_range(0, 99) < 5)
      hdr = byte_t'($urandom);
    else
      hdr = {4'($urandom_range(0, 15)),
             $urandom_range(0, 1) ? NAL_IDR[3:0] : NAL_NON[3:0]};
    queue_byte(hdr, 1'b0);
    pick = $urandom_range(0, 99);
    if (pick < 15)
      slice = byte_t'($urandom);
    else if (pick < 50)
      slice = slice_byte_of(KIND_P);
    else if (pick < 70)
      slice = slice_byte_of(KIND_B);
    else
      slice = slice_byte_of(KIND_I);
    queue_byte(slice, $urandom_range(0, 99) < 10);
  endfunction

  initial begin
    // zeros up to stage three, a zero held at stage four, header 01, then a B slice
    queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h01, 1'b0);
    queue_byte(8'h1c, 1'b0);
    // two I slices, the second on the final byte
    queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h01, 1'b0);
    queue_byte(8'h05, 1'b0); queue_byte(8'h08, 1'b0);
    queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h01, 1'b0);
    queue_byte(8'h15, 1'b0); queue_byte(8'h30, 1'b1);
    // unclassified slice byte restarts the prefix, then P and end of stream
    queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h01, 1'b0);
    queue_byte(8'h65, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'h01, 1'b0); queue_byte(8'h41, 1'b0); queue_byte(8'hff, 1'b1);
    while (byte_feed_q.size() < RandomBytes + 26) begin
      queue_picture();
      if ($urandom_range(0, 99) < 15)
        queue_byte(byte_t'($urandom), 1'b1);
    end
    total_bytes = byte_feed_q.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != total_bytes) @(posedge clk);
    while (decision_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d byte transactions scanned, %0d decisions checked (%0d at end of stream)",
             accepted_cnt, decision_cnt, end_decision_cnt);
    $display("decisions by kind: P %0d, B %0d, I %0d, mismatches %0d",
             kind_cnt[KIND_P], kind_cnt[KIND_B], kind_cnt[KIND_I], error_cnt);
    if (error_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // driver

  always @(posedge clk) begin : drive_bytes
    scan_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        scan_byte(in_stream_byte, in_end_of_stream);
        accepted_cnt = accepted_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if (byte_feed_q.size() != 0 && (steady || $urandom_range(0, 99) >= 26)) begin
          it = byte_feed_q.pop_front();
          in_valid <= 1'b1;
          in_stream_byte <= it.stream_byte;
          in_end_of_stream <= it.end_of_stream;
          sent_cnt = sent_cnt + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor

  task automatic report_mismatch(input string what, input int exp_v, input int act_v);
    error_cnt = error_cnt + 1;
    if (error_cnt <= 10)
      $display("mismatch at cycle %0d: %s expected %0d, got %0d", cycle_cnt, what, exp_v,
               act_v);
  endtask

  always @(posedge clk) begin : check_decisions
    decision_t d;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        decision_cnt = decision_cnt + 1;
        if (out_slice_kind <= 2'd2)
          kind_cnt[out_slice_kind] = kind_cnt[out_slice_kind] + 1;
        if (out_decided_by_end)
          end_decision_cnt = end_decision_cnt + 1;
        if (decision_q.size() == 0) begin
          report_mismatch("unexpected decision, kind", -1, int'(out_slice_kind));
        end else begin
          d = decision_q.pop_front();
          if (out_slice_kind !== d.kind)
            report_mismatch("slice_kind", int'(d.kind), int'(out_slice_kind));
          if (out_decided_by_end !== d.by_end)
            report_mismatch("decided_by_end", int'(d.by_end), int'(out_decided_by_end));
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 26);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d bytes accepted, %0d decisions pending",
               cycle_cnt, accepted_cnt, total_bytes, decision_q.size());
      $display("Verification failed");
      $finish;
    end
  end

endmodule
